// ===== hdl/euler_camera_basis_update_defines.svh =====
// Assertion macros for the camera basis block checker.
// Needs clk and rst_n in the scope of every use.
`ifndef EULER_CAMERA_BASIS_UPDATE_DEFINES_SVH
`define EULER_CAMERA_BASIS_UPDATE_DEFINES_SVH

// same-cycle implication, held off during reset
`define ECBU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ECBU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ecbu_pkg.sv =====
// Shared types, constants and tables of the camera basis block.
// No dependencies.
`default_nettype none

package ecbu_pkg;

  localparam int ANG_W      = 17;
  localparam int ZOOM_W     = 14;
  localparam int VEC_W      = 16;
  localparam int OFS_W      = 12;
  localparam int SCR_W      = 8;
  localparam int SENS_W     = 16;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int WIDE_W     = 21;
  localparam int CORD_W     = 32;
  localparam int Z_W        = 26;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;

  localparam logic signed [WIDE_W-1:0] HALF_TURN    = 21'sd46080;
  localparam logic signed [WIDE_W-1:0] FULL_TURN    = 21'sd92160;
  localparam logic signed [WIDE_W-1:0] PITCH_LIMIT  = 21'sd22784;
  localparam logic signed [ANG_W-1:0]  QUARTER_TURN = 17'sd23040;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN  = 32'sd652032874;
  localparam logic signed [VEC_W:0]    ONE_Q14      = 17'sd16384;
  localparam logic [ZOOM_W-1:0]        ZOOM_MIN     = 14'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS        = 3'd0,
    CFG_WUP_X       = 3'd1,
    CFG_WUP_Y       = 3'd2,
    CFG_WUP_Z       = 3'd3,
    CFG_START_YAW   = 3'd4,
    CFG_START_PITCH = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_ADD,
    F_WRAP,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CORD,
    B_FM1,
    B_FM2,
    B_FM3,
    B_CROSS,
    B_SQ,
    B_SQRT,
    B_DINIT,
    B_DIV,
    B_DSTORE,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] pitch;
    logic [ZOOM_W-1:0]       zoom;
  } qitem_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } world_up_t;

  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic avail;
  } q_ctl_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [Z_W-1:0] atan_val(input logic [3:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      4'd0:    v = 26'sd2949120;
      4'd1:    v = 26'sd1740967;
      4'd2:    v = 26'sd919879;
      4'd3:    v = 26'sd466945;
      4'd4:    v = 26'sd234379;
      4'd5:    v = 26'sd117304;
      4'd6:    v = 26'sd58666;
      4'd7:    v = 26'sd29335;
      4'd8:    v = 26'sd14668;
      4'd9:    v = 26'sd7334;
      4'd10:   v = 26'sd3667;
      4'd11:   v = 26'sd1833;
      4'd12:   v = 26'sd917;
      4'd13:   v = 26'sd458;
      4'd14:   v = 26'sd229;
      default: v = 26'sd115;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ecbu_fifo.sv =====
// Two-entry queue between the front and back parts.
// Depends on ecbu_pkg.
`default_nettype none

module ecbu_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ecbu_pkg::q_ctl_t ctl_in,
  output ecbu_pkg::q_ctl_t     ctl_out,
  input  wire ecbu_pkg::qitem_t wr_data,
  output ecbu_pkg::qitem_t     rd_data
);
  import ecbu_pkg::*;

  qitem_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push, do_pop;

  assign do_push = ctl_in.push && (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign do_pop  = ctl_in.pop && (cnt_r != '0);

  always_comb begin
    ctl_out       = '0;
    ctl_out.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
    ctl_out.avail = (cnt_r != '0);
  end

  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_data;
  end

endmodule

`default_nettype wire

// ===== hdl/ecbu_front.sv =====
// Front part: accepts events, updates yaw, pitch and zoom, holds the registers.
// Depends on ecbu_pkg; feeds ecbu_fifo.
`default_nettype none

module ecbu_front #(
  parameter int MAX_ZOOM_DEG = 45
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [ecbu_pkg::OFS_W-1:0]    in_x_offset,
  input  wire logic signed [ecbu_pkg::OFS_W-1:0]    in_y_offset,
  input  wire logic signed [ecbu_pkg::SCR_W-1:0]    in_scroll_offset,
  input  wire logic                                 in_constrain_pitch,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ecbu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ecbu_pkg::CFG_DATA_W-1:0]      cfg_data,
  output ecbu_pkg::world_up_t                       world_up,
  output logic                                      q_push,
  input  wire logic                                 q_full,
  output ecbu_pkg::qitem_t                          q_data
);
  import ecbu_pkg::*;

  localparam int ZOOM_CAP_I = (MAX_ZOOM_DEG * 256 > 16383) ? 16383 : MAX_ZOOM_DEG * 256;
  localparam logic [ZOOM_W-1:0] ZOOM_CAP = ZOOM_W'(ZOOM_CAP_I);
  localparam int PROD_W = OFS_W + SENS_W + 1;

  front_state_t st_r, st_nxt;

  logic [SENS_W-1:0]       sens_r;
  world_up_t               wu_r;
  logic signed [ANG_W-1:0] yaw_r, pitch_r;
  logic [ZOOM_W-1:0]       zoom_r;

  logic signed [OFS_W-1:0]  xo_r, yo_r;
  logic signed [SCR_W-1:0]  so_r;
  logic                     cp_r;
  logic signed [WIDE_W-1:0] dy_r, dp_r, ya_r, pa_r;
  logic [ZOOM_W-1:0]        za_r;

  logic signed [PROD_W-1:0] px, py;
  logic signed [ZOOM_W+3:0] zs;
  logic [ZOOM_W-1:0]        zc;
  logic y_hi, y_lo, p_hi, p_lo, p_above, p_below, y_ok, p_ok;
  logic signed [WIDE_W-1:0] ya_nxt, pa_nxt;

  function automatic logic signed [ANG_W-1:0] wrap17(input logic [ANG_W-1:0] v);
    logic signed [ANG_W:0] s;
    s = $signed({v[ANG_W-1], v});
    if (s >= 18'sd46080) s = s - 18'sd92160;
    else if (s < -18'sd46080) s = s + 18'sd92160;
    return s[ANG_W-1:0];
  endfunction

  // delta = floor((offset * sens + 128) / 256)
  assign px = $signed({{(PROD_W-OFS_W){xo_r[OFS_W-1]}}, xo_r}) *
              $signed({{(PROD_W-SENS_W){1'b0}}, sens_r}) + PROD_W'(128);
  assign py = $signed({{(PROD_W-OFS_W){yo_r[OFS_W-1]}}, yo_r}) *
              $signed({{(PROD_W-SENS_W){1'b0}}, sens_r}) + PROD_W'(128);

  always_comb begin
    zs = $signed({4'd0, zoom_r}) - $signed({{(ZOOM_W+4-SCR_W-8){so_r[SCR_W-1]}}, so_r, 8'd0});
    if (zs < $signed({4'd0, ZOOM_MIN})) zc = ZOOM_MIN;
    else if (zs > $signed({4'd0, ZOOM_CAP})) zc = ZOOM_CAP;
    else zc = zs[ZOOM_W-1:0];
  end

  always_comb begin
    y_hi    = ya_r >= HALF_TURN;
    y_lo    = ya_r < -HALF_TURN;
    p_hi    = pa_r >= HALF_TURN;
    p_lo    = pa_r < -HALF_TURN;
    p_above = pa_r > PITCH_LIMIT;
    p_below = pa_r < -PITCH_LIMIT;
    y_ok    = !y_hi && !y_lo;
    p_ok    = cp_r ? !(p_above || p_below) : !(p_hi || p_lo);
    if (y_hi) ya_nxt = ya_r - FULL_TURN;
    else if (y_lo) ya_nxt = ya_r + FULL_TURN;
    else ya_nxt = ya_r;
    if (cp_r) begin
      if (p_above) pa_nxt = PITCH_LIMIT;
      else if (p_below) pa_nxt = -PITCH_LIMIT;
      else pa_nxt = pa_r;
    end else begin
      if (p_hi) pa_nxt = pa_r - FULL_TURN;
      else if (p_lo) pa_nxt = pa_r + FULL_TURN;
      else pa_nxt = pa_r;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE: if (in_valid) st_nxt = F_MUL;
      F_MUL:  st_nxt = F_ADD;
      F_ADD:  st_nxt = F_WRAP;
      F_WRAP: if (y_ok && p_ok) st_nxt = F_PUSH;
      F_PUSH: if (!q_full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (st_r == F_IDLE);
    q_push   = (st_r == F_PUSH) && !q_full;
  end

  assign cfg_ready    = 1'b1;
  assign world_up     = wu_r;
  assign q_data.yaw   = ya_r[ANG_W-1:0];
  assign q_data.pitch = pa_r[ANG_W-1:0];
  assign q_data.zoom  = za_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= F_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r  <= 16'd6554;
      wu_r    <= '{x: 16'sd0, y: 16'sd16384, z: 16'sd0};
      yaw_r   <= -17'sd23040;
      pitch_r <= 17'sd0;
      zoom_r  <= ZOOM_CAP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SENS:        sens_r  <= cfg_data[SENS_W-1:0];
        CFG_WUP_X:       wu_r.x  <= cfg_data[VEC_W-1:0];
        CFG_WUP_Y:       wu_r.y  <= cfg_data[VEC_W-1:0];
        CFG_WUP_Z:       wu_r.z  <= cfg_data[VEC_W-1:0];
        CFG_START_YAW:   yaw_r   <= wrap17(cfg_data);
        CFG_START_PITCH: pitch_r <= wrap17(cfg_data);
        default: ;
      endcase
    end else if (q_push) begin
      // commit the updated angles and zoom as the beat leaves; a cfg write in that cycle wins
      yaw_r   <= ya_r[ANG_W-1:0];
      pitch_r <= pa_r[ANG_W-1:0];
      zoom_r  <= za_r;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      F_IDLE: if (in_valid) begin
        xo_r <= in_x_offset;
        yo_r <= in_y_offset;
        so_r <= in_scroll_offset;
        cp_r <= in_constrain_pitch;
      end
      F_MUL: begin
        dy_r <= px[PROD_W-1:8];
        dp_r <= py[PROD_W-1:8];
      end
      F_ADD: begin
        ya_r <= WIDE_W'(yaw_r) + dy_r;
        pa_r <= WIDE_W'(pitch_r) + dp_r;
        za_r <= zc;
      end
      F_WRAP: begin
        ya_r <= ya_nxt;
        pa_r <= pa_nxt;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ecbu_back.sv =====
// Back part: CORDIC sine/cosine, front vector, two normalized cross products.
// Depends on ecbu_pkg; drains ecbu_fifo and drives the result registers.
`default_nettype none

module ecbu_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_avail,
  output logic                                  q_pop,
  input  wire ecbu_pkg::qitem_t                 q_data,
  input  wire ecbu_pkg::world_up_t              world_up,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [ecbu_pkg::VEC_W-1:0]     out_front_x,
  output logic signed [ecbu_pkg::VEC_W-1:0]     out_front_y,
  output logic signed [ecbu_pkg::VEC_W-1:0]     out_front_z,
  output logic signed [ecbu_pkg::VEC_W-1:0]     out_right_x,
  output logic signed [ecbu_pkg::VEC_W-1:0]     out_right_y,
  output logic signed [ecbu_pkg::VEC_W-1:0]     out_right_z,
  output logic signed [ecbu_pkg::VEC_W-1:0]     out_up_x,
  output logic signed [ecbu_pkg::VEC_W-1:0]     out_up_y,
  output logic signed [ecbu_pkg::VEC_W-1:0]     out_up_z,
  output logic signed [ecbu_pkg::ANG_W-1:0]     out_yaw_now,
  output logic signed [ecbu_pkg::ANG_W-1:0]     out_pitch_now,
  output logic [ecbu_pkg::ZOOM_W-1:0]           out_zoom_now
);
  import ecbu_pkg::*;

  back_state_t st_r, st_nxt;

  qitem_t                   item_r;
  logic [4:0]               cnt_r;
  logic [1:0]               k_r;
  logic                     pass_r, sel_r, flip_r;
  logic signed [CORD_W-1:0] cx_r, cy_r, cosy_r, siny_r, cosp_r, sinp_r;
  logic signed [Z_W-1:0]    cz_r;
  logic signed [63:0]       prod_r;
  logic signed [VEC_W:0]    f_r [3];
  logic signed [VEC_W:0]    r_r [3];
  logic signed [VEC_W:0]    u_r [3];
  logic signed [31:0]       c_r [3];
  logic [61:0]              acc_r, n_r, res_r;
  logic [30:0]              len_r;
  logic [46:0]              rem_r, dsh_r;
  logic [14:0]              q_r;
  logic                     out_valid_r;

  logic signed [CORD_W-1:0] sx, sy, xn, yn;
  logic signed [Z_W-1:0]    zn;
  logic signed [63:0]       t46;
  logic signed [CORD_W-1:0] t16;
  logic signed [VEC_W:0]    a_v [3];
  logic signed [VEC_W:0]    b_v [3];
  logic signed [2*VEC_W+1:0] m1, m2, cfull;
  logic signed [31:0]       c_sel, c_abs;
  logic [30:0]              mag;
  logic [61:0]              sq, bitv, trial;
  logic                     sq_ge, d_ge, last_k, out_free, out_load;
  logic [14:0]              qc;
  logic signed [VEC_W:0]    qv;

  function automatic logic signed [VEC_W:0] sat17(input logic signed [23:0] v);
    if (v > 24'sd16384) return ONE_Q14;
    if (v < -24'sd16384) return -ONE_Q14;
    return v[VEC_W:0];
  endfunction

  function automatic logic needs_flip(input logic signed [ANG_W-1:0] a);
    return (a > QUARTER_TURN) || (a < -QUARTER_TURN);
  endfunction

  // fold into +-90 degrees by a half turn, then scale to 1/65536 degree
  function automatic logic signed [Z_W-1:0] red_z(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W:0] t;
    t = {a[ANG_W-1], a};
    if (a > QUARTER_TURN) t = t - 18'sd46080;
    else if (a < -QUARTER_TURN) t = t + 18'sd46080;
    return $signed({t[ANG_W-1], t[ANG_W-1:0], 8'd0});
  endfunction

  // CORDIC rotation step
  always_comb begin
    sx = cx_r >>> cnt_r[3:0];
    sy = cy_r >>> cnt_r[3:0];
    if (cz_r >= 0) begin
      xn = cx_r - sy;
      yn = cy_r + sx;
      zn = cz_r - atan_val(cnt_r[3:0]);
    end else begin
      xn = cx_r + sy;
      yn = cy_r - sx;
      zn = cz_r + atan_val(cnt_r[3:0]);
    end
  end

  assign t46 = prod_r + (64'sd1 <<< 45);
  assign t16 = sinp_r + 32'sd32768;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      a_v[j] = pass_r ? r_r[j] : f_r[j];
      b_v[j] = pass_r ? f_r[j] : 17'sd0;
    end
    if (!pass_r) begin
      b_v[0] = {world_up.x[VEC_W-1], world_up.x};
      b_v[1] = {world_up.y[VEC_W-1], world_up.y};
      b_v[2] = {world_up.z[VEC_W-1], world_up.z};
    end
  end

  always_comb begin
    case (k_r)
      2'd0: begin
        m1 = a_v[1] * b_v[2];
        m2 = a_v[2] * b_v[1];
        c_sel = c_r[0];
      end
      2'd1: begin
        m1 = a_v[2] * b_v[0];
        m2 = a_v[0] * b_v[2];
        c_sel = c_r[1];
      end
      default: begin
        m1 = a_v[0] * b_v[1];
        m2 = a_v[1] * b_v[0];
        c_sel = c_r[2];
      end
    endcase
    cfull = m1 - m2;
    c_abs = c_sel[31] ? -c_sel : c_sel;
    mag   = c_abs[30:0];
  end

  assign sq     = mag * mag;
  assign bitv   = 62'd1 << {cnt_r, 1'b0};
  assign trial  = res_r + bitv;
  assign sq_ge  = n_r >= trial;
  assign d_ge   = rem_r >= dsh_r;
  assign last_k = (k_r == 2'd2);

  always_comb begin
    qc = (q_r > 15'd16384) ? 15'd16384 : q_r;
    qv = c_sel[31] ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE:   if (q_avail) st_nxt = B_CORD;
      B_CORD:   if (cnt_r == 5'd15 && sel_r) st_nxt = B_FM1;
      B_FM1:    st_nxt = B_FM2;
      B_FM2:    st_nxt = B_FM3;
      B_FM3:    st_nxt = B_CROSS;
      B_CROSS:  if (last_k) st_nxt = B_SQ;
      B_SQ:     if (last_k) st_nxt = B_SQRT;
      B_SQRT:   if (cnt_r == 5'd0) st_nxt = B_DINIT;
      B_DINIT: begin
        if (len_r != '0) st_nxt = B_DIV;
        else if (last_k) st_nxt = pass_r ? B_DONE : B_CROSS;
      end
      B_DIV:    if (cnt_r == 5'd0) st_nxt = B_DSTORE;
      B_DSTORE: begin
        if (last_k) st_nxt = pass_r ? B_DONE : B_CROSS;
        else st_nxt = B_DINIT;
      end
      B_DONE:   if (out_free) st_nxt = B_IDLE;
      default:  st_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_free = !out_valid_r || out_ready;
    q_pop    = (st_r == B_IDLE) && q_avail;
    out_load = (st_r == B_DONE) && out_free;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: if (q_avail) begin
        item_r <= q_data;
        cx_r   <= CORDIC_GAIN;
        cy_r   <= '0;
        cz_r   <= red_z(q_data.yaw);
        flip_r <= needs_flip(q_data.yaw);
        cnt_r  <= '0;
        sel_r  <= 1'b0;
      end
      B_CORD: begin
        if (cnt_r == 5'd15 && !sel_r) begin
          cosy_r <= flip_r ? -xn : xn;
          siny_r <= flip_r ? -yn : yn;
          // reload for pitch
          cx_r   <= CORDIC_GAIN;
          cy_r   <= '0;
          cz_r   <= red_z(item_r.pitch);
          flip_r <= needs_flip(item_r.pitch);
          cnt_r  <= '0;
          sel_r  <= 1'b1;
        end else begin
          cx_r  <= xn;
          cy_r  <= yn;
          cz_r  <= zn;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd15) begin
            cosp_r <= flip_r ? -xn : xn;
            sinp_r <= flip_r ? -yn : yn;
          end
        end
      end
      B_FM1: prod_r <= cosy_r * cosp_r;
      B_FM2: begin
        f_r[0] <= sat17($signed({{6{t46[63]}}, t46[63:46]}));
        prod_r <= siny_r * cosp_r;
      end
      B_FM3: begin
        f_r[2] <= sat17($signed({{6{t46[63]}}, t46[63:46]}));
        f_r[1] <= sat17($signed({{8{t16[31]}}, t16[31:16]}));
        k_r    <= '0;
        pass_r <= 1'b0;
      end
      B_CROSS: begin
        for (int j = 0; j < 3; j++) begin
          if (k_r == 2'(j)) c_r[j] <= cfull[31:0];
        end
        acc_r <= '0;
        k_r   <= last_k ? 2'd0 : k_r + 2'd1;
      end
      B_SQ: begin
        acc_r <= acc_r + sq;
        k_r   <= last_k ? 2'd0 : k_r + 2'd1;
        if (last_k) begin
          n_r   <= acc_r + sq;
          res_r <= '0;
          cnt_r <= 5'd30;
        end
      end
      B_SQRT: begin
        n_r   <= sq_ge ? n_r - trial : n_r;
        res_r <= sq_ge ? (res_r >> 1) + bitv : res_r >> 1;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) len_r <= sq_ge ? 31'((res_r >> 1) + bitv) : 31'(res_r >> 1);
      end
      B_DINIT: begin
        if (len_r != '0) begin
          rem_r <= {1'b0, mag, 15'd0} + {16'd0, len_r};
          dsh_r <= {1'b0, len_r, 15'd0};
          q_r   <= '0;
          cnt_r <= 5'd14;
        end else begin
          // zero-length cross: zero component
          for (int j = 0; j < 3; j++) begin
            if (k_r == 2'(j)) begin
              if (pass_r) u_r[j] <= '0;
              else r_r[j] <= '0;
            end
          end
          k_r <= last_k ? 2'd0 : k_r + 2'd1;
          if (last_k) pass_r <= 1'b1;
        end
      end
      B_DIV: begin
        if (d_ge) rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[13:0], d_ge};
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 5'd1;
      end
      B_DSTORE: begin
        for (int j = 0; j < 3; j++) begin
          if (k_r == 2'(j)) begin
            if (pass_r) u_r[j] <= qv;
            else r_r[j] <= qv;
          end
        end
        k_r <= last_k ? 2'd0 : k_r + 2'd1;
        if (last_k) pass_r <= 1'b1;
      end
      B_DONE: if (out_free) begin
        out_front_x   <= f_r[0][VEC_W-1:0];
        out_front_y   <= f_r[1][VEC_W-1:0];
        out_front_z   <= f_r[2][VEC_W-1:0];
        out_right_x   <= r_r[0][VEC_W-1:0];
        out_right_y   <= r_r[1][VEC_W-1:0];
        out_right_z   <= r_r[2][VEC_W-1:0];
        out_up_x      <= u_r[0][VEC_W-1:0];
        out_up_y      <= u_r[1][VEC_W-1:0];
        out_up_z      <= u_r[2][VEC_W-1:0];
        out_yaw_now   <= item_r.yaw;
        out_pitch_now <= item_r.pitch;
        out_zoom_now  <= item_r.zoom;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/euler_camera_basis_update.sv =====
// Top level of the camera basis block: front, queue and back.
// Depends on ecbu_pkg, ecbu_front, ecbu_fifo, ecbu_back.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | x, y, scroll offsets, constrain flag
//   out_    | output    | out_valid/out_ready  | front, right, up, yaw, pitch, zoom
//   cfg_    | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// The front takes one event at a time and repeats its wrap state until the angles
// are in range. The back takes one item at a time through the CORDIC passes, the
// square root and the restoring divides, with no divide for a zero cross product.
// Reset is synchronous, active low; no clearing pass. A stalled result holds in the
// output register; the front keeps accepting until the two-entry queue fills.
`default_nettype none

module euler_camera_basis_update #(
  parameter int MAX_ZOOM_DEG = 45
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [ecbu_pkg::OFS_W-1:0]    in_x_offset,
  input  wire logic signed [ecbu_pkg::OFS_W-1:0]    in_y_offset,
  input  wire logic signed [ecbu_pkg::SCR_W-1:0]    in_scroll_offset,
  input  wire logic                                 in_constrain_pitch,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [ecbu_pkg::VEC_W-1:0]         out_front_x,
  output logic signed [ecbu_pkg::VEC_W-1:0]         out_front_y,
  output logic signed [ecbu_pkg::VEC_W-1:0]         out_front_z,
  output logic signed [ecbu_pkg::VEC_W-1:0]         out_right_x,
  output logic signed [ecbu_pkg::VEC_W-1:0]         out_right_y,
  output logic signed [ecbu_pkg::VEC_W-1:0]         out_right_z,
  output logic signed [ecbu_pkg::VEC_W-1:0]         out_up_x,
  output logic signed [ecbu_pkg::VEC_W-1:0]         out_up_y,
  output logic signed [ecbu_pkg::VEC_W-1:0]         out_up_z,
  output logic signed [ecbu_pkg::ANG_W-1:0]         out_yaw_now,
  output logic signed [ecbu_pkg::ANG_W-1:0]         out_pitch_now,
  output logic [ecbu_pkg::ZOOM_W-1:0]               out_zoom_now,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ecbu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ecbu_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ecbu_pkg::*;

  world_up_t wu;
  qitem_t    wr_item, rd_item;
  q_ctl_t    q_req, q_stat;
  logic      push, pop;

  always_comb begin
    q_req      = '0;
    q_req.push = push;
    q_req.pop  = pop;
  end

  ecbu_front #(
    .MAX_ZOOM_DEG(MAX_ZOOM_DEG)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_x_offset        (in_x_offset),
    .in_y_offset        (in_y_offset),
    .in_scroll_offset   (in_scroll_offset),
    .in_constrain_pitch (in_constrain_pitch),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .world_up           (wu),
    .q_push             (push),
    .q_full             (q_stat.full),
    .q_data             (wr_item)
  );

  ecbu_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (q_req),
    .ctl_out (q_stat),
    .wr_data (wr_item),
    .rd_data (rd_item)
  );

  ecbu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_avail       (q_stat.avail),
    .q_pop         (pop),
    .q_data        (rd_item),
    .world_up      (wu),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_front_x   (out_front_x),
    .out_front_y   (out_front_y),
    .out_front_z   (out_front_z),
    .out_right_x   (out_right_x),
    .out_right_y   (out_right_y),
    .out_right_z   (out_right_z),
    .out_up_x      (out_up_x),
    .out_up_y      (out_up_y),
    .out_up_z      (out_up_z),
    .out_yaw_now   (out_yaw_now),
    .out_pitch_now (out_pitch_now),
    .out_zoom_now  (out_zoom_now)
  );

endmodule

`default_nettype wire

// ===== hdl/ecbu_chk.sv =====
// Port-level checker for the camera basis block, bound to the top level.
// Depends on euler_camera_basis_update_defines.svh.
`default_nettype none
`include "euler_camera_basis_update_defines.svh"

module ecbu_chk #(
  parameter int MAX_ZOOM_DEG = 45
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [16:0] out_yaw_now,
  input wire logic signed [16:0] out_pitch_now,
  input wire logic [13:0]        out_zoom_now
);
  localparam int ZCAP_I = (MAX_ZOOM_DEG * 256 > 16383) ? 16383 : MAX_ZOOM_DEG * 256;
  localparam logic [13:0] ZCAP = 14'(ZCAP_I);

  `ECBU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ECBU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_yaw_now) && $stable(out_zoom_now), "stalled result changed")
  `ECBU_ASSERT_NOW(a_zoom_range, out_valid, out_zoom_now >= 14'd256 && out_zoom_now <= ZCAP, "zoom out of range")
  `ECBU_ASSERT_NOW(a_angle_range, out_valid, out_pitch_now >= -17'sd46080 && out_yaw_now >= -17'sd46080 && out_yaw_now <= 17'sd46079, "angle out of range")

endmodule

bind euler_camera_basis_update ecbu_chk #(
  .MAX_ZOOM_DEG(MAX_ZOOM_DEG)
) u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_yaw_now   (out_yaw_now),
  .out_pitch_now (out_pitch_now),
  .out_zoom_now  (out_zoom_now)
);

`default_nettype wire
